### sv/regex_escape_decoder_unit_assert.svh
// ---------------------------------------------------------------------------
// regex escape decoder assertion macros
// shared property forms for the escape decoder checks
// ---------------------------------------------------------------------------
`ifndef REGEX_ESCAPE_DECODER_UNIT_ASSERT_SVH
`define REGEX_ESCAPE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define RXD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("regex escape decoder check failed");

// next-cycle implication, disabled while reset is high
`define RXD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("regex escape decoder check failed");

`endif

### sv/rxd_pkg.sv
// ---------------------------------------------------------------------------
// rxd_pkg
// widths, result kinds, character codes and digit helpers of the decoder
// ---------------------------------------------------------------------------
package rxd_pkg;

   localparam int CP_W    = 21;
   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int DLEFT_W = 3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_LITERAL   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DIGITS    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SPACES    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NONSPACES = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd4;

   // escape letters
   localparam logic [CP_W-1:0] CP_LOWER_A = 21'h61;
   localparam logic [CP_W-1:0] CP_LOWER_B = 21'h62;
   localparam logic [CP_W-1:0] CP_LOWER_F = 21'h66;
   localparam logic [CP_W-1:0] CP_LOWER_N = 21'h6E;
   localparam logic [CP_W-1:0] CP_LOWER_R = 21'h72;
   localparam logic [CP_W-1:0] CP_LOWER_T = 21'h74;
   localparam logic [CP_W-1:0] CP_LOWER_V = 21'h76;
   localparam logic [CP_W-1:0] CP_LOWER_D = 21'h64;
   localparam logic [CP_W-1:0] CP_LOWER_S = 21'h73;
   localparam logic [CP_W-1:0] CP_UPPER_S = 21'h53;
   localparam logic [CP_W-1:0] CP_LOWER_X = 21'h78;
   localparam logic [CP_W-1:0] CP_LOWER_U = 21'h75;
   localparam logic [CP_W-1:0] CP_UPPER_U = 21'h55;
   localparam logic [CP_W-1:0] CP_DIGIT_0 = 21'h30;
   localparam logic [CP_W-1:0] CP_DIGIT_7 = 21'h37;
   localparam logic [CP_W-1:0] CP_DIGIT_9 = 21'h39;
   localparam logic [CP_W-1:0] CP_UPPER_A = 21'h41;
   localparam logic [CP_W-1:0] CP_UPPER_F = 21'h46;
   localparam logic [CP_W-1:0] CP_NUL     = 21'h00;
   localparam logic [CP_W-1:0] CP_ETX     = 21'h03;
   localparam logic [CP_W-1:0] CP_EOT     = 21'h04;

   // control codes
   localparam logic [VALUE_W-1:0] CHR_BEL = 32'h07;
   localparam logic [VALUE_W-1:0] CHR_BS  = 32'h08;
   localparam logic [VALUE_W-1:0] CHR_FF  = 32'h0C;
   localparam logic [VALUE_W-1:0] CHR_LF  = 32'h0A;
   localparam logic [VALUE_W-1:0] CHR_CR  = 32'h0D;
   localparam logic [VALUE_W-1:0] CHR_HT  = 32'h09;
   localparam logic [VALUE_W-1:0] CHR_VT  = 32'h0B;

   // digits still expected after the escape letter, minus one
   localparam logic [DLEFT_W-1:0] DLEFT_HEX2 = 3'd1;
   localparam logic [DLEFT_W-1:0] DLEFT_HEX4 = 3'd3;
   localparam logic [DLEFT_W-1:0] DLEFT_HEX8 = 3'd7;
   localparam logic [DLEFT_W-1:0] DLEFT_OCT  = 3'd1;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   // hex digit check and value
   function automatic digit_type hex_digit(input logic [CP_W-1:0] cp);
      digit_type d;
      d.ok    = 1'b0;
      d.value = cp[3:0];
      if (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_9) begin
         d.ok = 1'b1;
      end else if ((cp >= CP_UPPER_A && cp <= CP_UPPER_F) ||
                   (cp >= CP_LOWER_A && cp <= CP_LOWER_F)) begin
         d.ok    = 1'b1;
         d.value = 4'(cp[3:0] + 4'd9);
      end
      return d;
   endfunction

   // octal digit check and value
   function automatic digit_type oct_digit(input logic [CP_W-1:0] cp);
      digit_type d;
      d.ok    = (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_7);
      d.value = {1'b0, cp[2:0]};
      return d;
   endfunction

endpackage

### sv/rxd_req_if.sv
// ---------------------------------------------------------------------------
// rxd_req_if
// code point channel into the escape decoder
// ---------------------------------------------------------------------------
interface rxd_req_if
   import rxd_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;

   modport source (output valid, output code_point, input ready);
   modport sink (input valid, input code_point, output ready);
endinterface

### sv/rxd_rsp_if.sv
// ---------------------------------------------------------------------------
// rxd_rsp_if
// result channel out of the escape decoder
// ---------------------------------------------------------------------------
interface rxd_rsp_if
   import rxd_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [VALUE_W-1:0] char_value;

   modport source (output valid, output kind, output char_value, input ready);
   modport sink (input valid, input kind, input char_value, output ready);
endinterface

### sv/regex_escape_decoder_unit.sv
// ---------------------------------------------------------------------------
// regex escape decoder
// decodes the code points after a backslash into literals, class tokens
// or errors, collecting hex and octal digits across items
// ---------------------------------------------------------------------------
//  channel  | dir | payload                  | handshake
//  ---------+-----+--------------------------+------------------------
//  req_if   | in  | code_point[20:0]         | valid/ready, code point
//  rsp_if   | out | kind[2:0], char_value    | valid/ready, one result
//
//  one item per cycle sustained while the result side is not stalled;
//  an item passes through the input register, then the result register
//  the decode and the shift-and-add of the accumulator sit between them
//  reset clears the escape state and both valid flags
//  a stalled result holds the input register, even when the held item
//  gives no result; the input side accepts again once the result moves on
// ---------------------------------------------------------------------------
`include "regex_escape_decoder_unit_assert.svh"

module regex_escape_decoder_unit
   import rxd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   rxd_req_if.sink   req_if,
   rxd_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_HEX  = 2'd1,
      MODE_OCT  = 2'd2
   } mode_type;

   logic               in_valid_ff, in_valid_in;
   logic [CP_W-1:0]    cp_ff, cp_in;
   mode_type           mode_ff, mode_in;
   logic [DLEFT_W-1:0] dleft_ff, dleft_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   logic               out_free;
   logic               fire;
   logic               req_take;
   logic               emit;
   logic [KIND_W-1:0]  res_kind;
   logic [VALUE_W-1:0] res_value;
   mode_type           nx_mode;
   logic [DLEFT_W-1:0] nx_dleft;
   logic [VALUE_W-1:0] nx_acc;
   digit_type          hex_d;
   digit_type          oct_d;
   logic [VALUE_W-1:0] acc_hex;
   logic [VALUE_W-1:0] acc_oct;

   // handshake control
   assign out_free   = !out_valid_ff || rsp_if.ready;
   assign fire       = in_valid_ff && out_free;
   assign req_take   = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || fire;

   // digit values and accumulator steps
   assign hex_d   = hex_digit(cp_ff);
   assign oct_d   = oct_digit(cp_ff);
   assign acc_hex = {acc_ff[VALUE_W-5:0], hex_d.value};
   assign acc_oct = {acc_ff[VALUE_W-4:0], oct_d.value[2:0]};

   // escape decode for the held item
   always_comb begin
      emit      = 1'b0;
      res_kind  = KIND_LITERAL;
      res_value = '0;
      nx_mode   = mode_ff;
      nx_dleft  = dleft_ff;
      nx_acc    = acc_ff;
      unique case (mode_ff)
         MODE_HEX, MODE_OCT: begin
            if ((mode_ff == MODE_HEX) ? !hex_d.ok : !oct_d.ok) begin
               emit     = 1'b1;
               res_kind = KIND_ERROR;
               nx_mode  = MODE_IDLE;
               nx_dleft = '0;
               nx_acc   = '0;
            end else if (dleft_ff == '0) begin
               emit      = 1'b1;
               res_value = (mode_ff == MODE_HEX) ? acc_hex : acc_oct;
               nx_mode   = MODE_IDLE;
               nx_acc    = '0;
            end else begin
               nx_dleft = dleft_ff - 1'b1;
               nx_acc   = (mode_ff == MODE_HEX) ? acc_hex : acc_oct;
            end
         end
         default: begin
            // idle, and the unused code treated as idle
            nx_mode  = MODE_IDLE;
            nx_dleft = '0;
            nx_acc   = '0;
            emit     = 1'b1;
            unique case (cp_ff) inside
               CP_LOWER_A: res_value = CHR_BEL;
               CP_LOWER_B: res_value = CHR_BS;
               CP_LOWER_F: res_value = CHR_FF;
               CP_LOWER_N: res_value = CHR_LF;
               CP_LOWER_R: res_value = CHR_CR;
               CP_LOWER_T: res_value = CHR_HT;
               CP_LOWER_V: res_value = CHR_VT;
               CP_LOWER_D: res_kind = KIND_DIGITS;
               CP_LOWER_S: res_kind = KIND_SPACES;
               CP_UPPER_S: res_kind = KIND_NONSPACES;
               CP_LOWER_X: begin
                  emit     = 1'b0;
                  nx_mode  = MODE_HEX;
                  nx_dleft = DLEFT_HEX2;
               end
               CP_LOWER_U: begin
                  emit     = 1'b0;
                  nx_mode  = MODE_HEX;
                  nx_dleft = DLEFT_HEX4;
               end
               CP_UPPER_U: begin
                  emit     = 1'b0;
                  nx_mode  = MODE_HEX;
                  nx_dleft = DLEFT_HEX8;
               end
               [CP_DIGIT_0:CP_DIGIT_7]: begin
                  // the escape letter is the first of three octal digits
                  emit     = 1'b0;
                  nx_mode  = MODE_OCT;
                  nx_dleft = DLEFT_OCT;
                  nx_acc   = VALUE_W'(oct_d.value[2:0]);
               end
               CP_NUL, CP_ETX, CP_EOT: res_kind = KIND_ERROR;
               default: res_value = VALUE_W'(cp_ff);
            endcase
         end
      endcase
   end

   // next values of the registers
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      cp_in        = req_take ? req_if.code_point : cp_ff;
      mode_in      = fire ? nx_mode : mode_ff;
      dleft_in     = fire ? nx_dleft : dleft_ff;
      acc_in       = fire ? nx_acc : acc_ff;
      out_valid_in = out_free ? (fire && emit) : out_valid_ff;
      kind_in      = (fire && emit) ? res_kind : kind_ff;
      value_in     = (fire && emit) ? res_value : value_ff;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mode_ff      <= MODE_IDLE;
         dleft_ff     <= '0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mode_ff      <= mode_in;
         dleft_ff     <= dleft_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
      cp_ff    <= cp_in;
      kind_ff  <= kind_in;
      value_ff <= value_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.kind       = kind_ff;
   assign rsp_if.char_value = value_ff;

   // checks on the escape state and the result register
   `RXD_ASSERT_NOW(a_idle_clear, clock, reset, mode_ff == MODE_IDLE,
      dleft_ff == '0 && acc_ff == '0)
   `RXD_ASSERT_NOW(a_oct_count, clock, reset, mode_ff == MODE_OCT, dleft_ff <= DLEFT_OCT)
   `RXD_ASSERT_NOW(a_class_zero, clock, reset,
      out_valid_ff && kind_ff != KIND_LITERAL, value_ff == '0)
   `RXD_ASSERT_NEXT(a_no_drop, clock, reset, fire && emit, out_valid_ff)

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// testbench for the regex escape decoder: code points go in through a
// queued driver with random gaps, results are checked in order against a
// cycle-free predictor of the escape decoding, with random and long stalls
// on the result side
// ---------------------------------------------------------------------------
module tb;
   import rxd_pkg::*;

   typedef logic [CP_W-1:0] code_point_t;

   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_HEX  = 2'd1,
      ESC_OCT  = 2'd2
   } escape_mode_t;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] char_value;
   } escape_result_t;

   localparam int unsigned HOLD_AT_ITEM = 1000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned MAX_REPORTS  = 40;

   logic clock;
   logic reset;

   rxd_req_if req_if();
   rxd_rsp_if rsp_if();

   regex_escape_decoder_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // predictor state, matching the block after reset
   escape_mode_t       esc_mode     = ESC_IDLE;
   logic [DLEFT_W-1:0] digits_to_go = '0;
   logic [VALUE_W-1:0] esc_acc      = '0;

   code_point_t    pending_code_points[$];
   escape_result_t expected_results[$];
   escape_result_t oldest_result;
   code_point_t    next_cp;

   int unsigned items_queued     = 0;
   int unsigned items_accepted   = 0;
   int unsigned results_checked  = 0;
   int unsigned mismatch_count   = 0;
   int unsigned numeric_literals = 0;
   int unsigned error_results    = 0;
   int unsigned send_gap         = 0;
   int unsigned recv_gap         = 0;
   bit          send_idle_on     = 1'b1;
   bit          recv_idle_on     = 1'b1;
   bit          hold_receiver    = 1'b0;

   // hex digit check and nibble value
   function automatic bit hex_nibble(input code_point_t cp, output logic [3:0] nib);
      nib = '0;
      if (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_9) begin
         nib = 4'(cp - CP_DIGIT_0);
         return 1'b1;
      end
      if (cp >= CP_UPPER_A && cp <= CP_UPPER_F) begin
         nib = 4'(cp - CP_UPPER_A + 10);
         return 1'b1;
      end
      if (cp >= CP_LOWER_A && cp <= CP_LOWER_F) begin
         nib = 4'(cp - CP_LOWER_A + 10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void queue_result(input logic [KIND_W-1:0] kind,
                                        input logic [VALUE_W-1:0] value);
      escape_result_t r;
      r.kind       = kind;
      r.char_value = value;
      if (kind == KIND_ERROR) error_results++;
      expected_results.push_back(r);
   endfunction

   // invalid digit drops the partial value and returns to idle
   function automatic void drop_escape();
      esc_mode     = ESC_IDLE;
      digits_to_go = '0;
      esc_acc      = '0;
      queue_result(KIND_ERROR, '0);
   endfunction

   // shift-and-add one digit, the last one gives the literal
   function automatic void add_digit(input logic [3:0] nib, input int unsigned radix);
      esc_acc = esc_acc * radix + VALUE_W'(nib);
      if (digits_to_go == 0) begin
         queue_result(KIND_LITERAL, esc_acc);
         numeric_literals++;
         esc_mode = ESC_IDLE;
         esc_acc  = '0;
      end else begin
         digits_to_go = digits_to_go - 1'b1;
      end
   endfunction

   // expected outcome of one accepted code point
   function automatic void predict_escape(input code_point_t cp);
      logic [3:0] nib;
      if (esc_mode == ESC_HEX) begin
         if (hex_nibble(cp, nib)) add_digit(nib, 16);
         else drop_escape();
      end else if (esc_mode == ESC_OCT) begin
         if (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_7) add_digit(4'(cp - CP_DIGIT_0), 8);
         else drop_escape();
      end else begin
         esc_mode     = ESC_IDLE;
         digits_to_go = '0;
         esc_acc      = '0;
         if (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_7) begin
            // leading octal digit is the first of three
            esc_mode     = ESC_OCT;
            digits_to_go = DLEFT_OCT;
            esc_acc      = VALUE_W'(cp - CP_DIGIT_0);
         end else begin
            case (cp)
               CP_LOWER_A: queue_result(KIND_LITERAL, CHR_BEL);
               CP_LOWER_B: queue_result(KIND_LITERAL, CHR_BS);
               CP_LOWER_F: queue_result(KIND_LITERAL, CHR_FF);
               CP_LOWER_N: queue_result(KIND_LITERAL, CHR_LF);
               CP_LOWER_R: queue_result(KIND_LITERAL, CHR_CR);
               CP_LOWER_T: queue_result(KIND_LITERAL, CHR_HT);
               CP_LOWER_V: queue_result(KIND_LITERAL, CHR_VT);
               CP_LOWER_D: queue_result(KIND_DIGITS, '0);
               CP_LOWER_S: queue_result(KIND_SPACES, '0);
               CP_UPPER_S: queue_result(KIND_NONSPACES, '0);
               CP_LOWER_X: begin
                  esc_mode     = ESC_HEX;
                  digits_to_go = DLEFT_HEX2;
               end
               CP_LOWER_U: begin
                  esc_mode     = ESC_HEX;
                  digits_to_go = DLEFT_HEX4;
               end
               CP_UPPER_U: begin
                  esc_mode     = ESC_HEX;
                  digits_to_go = DLEFT_HEX8;
               end
               CP_NUL, CP_ETX, CP_EOT: queue_result(KIND_ERROR, '0);
               default: queue_result(KIND_LITERAL, VALUE_W'(cp));
            endcase
         end
      end
   endfunction

   function automatic void push_cp(input code_point_t cp);
      pending_code_points.push_back(cp);
      items_queued++;
   endfunction

   function automatic int unsigned pick_gap(input bit idle_on);
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic code_point_t eos_cp();
      case ($urandom_range(2))
         0: return CP_NUL;
         1: return CP_ETX;
         default: return CP_EOT;
      endcase
   endfunction

   function automatic code_point_t hex_cp();
      int unsigned v;
      v = $urandom_range(15);
      if (v < 10) return CP_DIGIT_0 + code_point_t'(v);
      if ($urandom_range(1)) return CP_UPPER_A + code_point_t'(v - 10);
      return CP_LOWER_A + code_point_t'(v - 10);
   endfunction

   // a code point that breaks off a numeric escape
   function automatic code_point_t bad_digit_cp(input bit octal);
      code_point_t cp;
      logic [3:0]  nib;
      bit          good;
      do begin
         case ($urandom_range(3))
            0: cp = eos_cp();
            1: cp = CP_DIGIT_7 + code_point_t'($urandom_range(1, 2));
            2: cp = code_point_t'($urandom_range(127));
            default: cp = code_point_t'($urandom);
         endcase
         good = octal ? (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_7) : hex_nibble(cp, nib);
      end while (good);
      return cp;
   endfunction

   // x, u or U with its digits, optionally cut short by a bad digit
   function automatic void add_hex_escape(input bit broken);
      int unsigned ndig;
      int unsigned taken;
      case ($urandom_range(2))
         0: begin
            push_cp(CP_LOWER_X);
            ndig = 2;
         end
         1: begin
            push_cp(CP_LOWER_U);
            ndig = 4;
         end
         default: begin
            push_cp(CP_UPPER_U);
            ndig = 8;
         end
      endcase
      taken = broken ? $urandom_range(0, ndig - 1) : ndig;
      repeat (taken) push_cp(hex_cp());
      if (broken) push_cp(bad_digit_cp(1'b0));
   endfunction

   // three octal digits, optionally cut short by a bad digit
   function automatic void add_oct_escape(input bit broken);
      int unsigned taken;
      push_cp(CP_DIGIT_0 + code_point_t'($urandom_range(7)));
      taken = broken ? $urandom_range(0, 1) : 2;
      repeat (taken) push_cp(CP_DIGIT_0 + code_point_t'($urandom_range(7)));
      if (broken) push_cp(bad_digit_cp(1'b1));
   endfunction

   function automatic void add_letter_escape();
      case ($urandom_range(12))
         0: push_cp(CP_LOWER_A);
         1: push_cp(CP_LOWER_B);
         2: push_cp(CP_LOWER_F);
         3: push_cp(CP_LOWER_N);
         4: push_cp(CP_LOWER_R);
         5: push_cp(CP_LOWER_T);
         6: push_cp(CP_LOWER_V);
         7: push_cp(CP_LOWER_D);
         8: push_cp(CP_LOWER_S);
         9: push_cp(CP_UPPER_S);
         default: push_cp(eos_cp());
      endcase
   endfunction

   // mostly well-formed escapes, some literals and broken numeric escapes
   function automatic void add_random_escape();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) add_hex_escape(1'b0);
      else if (r < 55) add_oct_escape(1'b0);
      else if (r < 72) add_letter_escape();
      else if (r < 82) begin
         if ($urandom_range(1)) push_cp(code_point_t'($urandom));
         else push_cp(code_point_t'($urandom_range(32'h20, 32'h7E)));
      end else if (r < 91) add_hex_escape(1'b1);
      else add_oct_escape(1'b1);
   endfunction

   // every single-letter escape, end-of-stream codes, widest code point, full-width hex,
   // octal with the escape digit counted, and a hex escape hit by end of stream
   function automatic void add_directed();
      code_point_t seq[28];
      seq = '{CP_LOWER_A, CP_LOWER_B, CP_LOWER_F, CP_LOWER_N, CP_LOWER_R,
              CP_LOWER_T, CP_LOWER_V, CP_LOWER_D, CP_LOWER_S, CP_UPPER_S,
              CP_NUL, CP_ETX, CP_EOT, {CP_W{1'b1}},
              CP_UPPER_U, CP_LOWER_F, CP_UPPER_F, CP_DIGIT_9, CP_LOWER_A,
              CP_UPPER_A, CP_DIGIT_0, CP_UPPER_F, CP_LOWER_F,
              CP_DIGIT_0, CP_DIGIT_7, CP_DIGIT_7,
              CP_LOWER_X, CP_EOT};
      foreach (seq[i]) push_cp(seq[i]);
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                  results_checked, what, got, want);
      mismatch_count++;
   endtask

   // sender pause: wait until the queue is empty and every result is back
   task automatic wait_drained();
      while (pending_code_points.size() > 0 || req_if.valid || expected_results.size() > 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // driver: offers queued code points, predicts each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_escape(req_if.code_point);
            items_accepted++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_code_points.size() > 0) begin
               next_cp = pending_code_points.pop_front();
               req_if.valid      <= 1'b1;
               req_if.code_point <= next_cp;
               send_gap = pick_gap(send_idle_on);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, kind", VALUE_W'(rsp_if.kind), '0);
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_if.kind !== oldest_result.kind)
                  report_mismatch("kind", VALUE_W'(rsp_if.kind),
                                  VALUE_W'(oldest_result.kind));
               if (rsp_if.char_value !== oldest_result.char_value)
                  report_mismatch("char_value", rsp_if.char_value,
                                  oldest_result.char_value);
            end
         end
         if (hold_receiver) begin
            rsp_if.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            recv_gap = pick_gap(recv_idle_on);
         end
      end
   end

   // long receiver hold while the sender keeps offering
   initial begin : receiver_hold
      int unsigned held;
      wait (items_accepted >= HOLD_AT_ITEM);
      @(posedge clock);
      hold_receiver <= 1'b1;
      for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
      hold_receiver <= 1'b0;
   end

   // stimulus phases and end of run
   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.code_point = '0;
      rsp_if.ready      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_directed();
      wait_drained();

      // random escapes with gaps on both sides
      while (items_queued < 530) add_random_escape();
      wait_drained();

      // back-to-back stretch with no idling
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      while (items_queued < 830) add_random_escape();
      wait_drained();

      // gaps again, the long receiver hold falls in here
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      while (items_queued < 1450) add_random_escape();
      wait_drained();
      repeat (8) @(negedge clock);

      $display("run covered %0d code points and %0d results", items_accepted, results_checked);
      $display("  %0d hex/octal literals, %0d errors, receiver held %0d cycles once",
               numeric_literals, error_results, HOLD_CYCLES);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #6000000;
      $display("FAIL");
      $finish;
   end

endmodule
